// File: hdl/glyph_quad_text_layout_assert.svh
// Assertion shorthands on clk_i, with checks off while rst_ni is low.
`ifndef GLYPH_QUAD_TEXT_LAYOUT_ASSERT_SVH
`define GLYPH_QUAD_TEXT_LAYOUT_ASSERT_SVH

// Condition holds at every edge.
`define GQTL_ASSERT_NOW(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("gqtl check failed");

// Antecedent at one edge implies consequent at the next.
`define GQTL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gqtl check failed");

`endif

// File: hdl/gqtl_pkg.sv
`default_nettype none
package gqtl_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_GLYPH = 2'd0,
    CMD_LOAD_KERN  = 2'd1,
    CMD_START      = 2'd2,
    CMD_CHAR       = 2'd3
  } cmd_e;

  localparam logic [7:0] CFG_SCALE       = 8'd0;
  localparam logic [7:0] CFG_INV_ASPECT  = 8'd1;
  localparam logic [7:0] CFG_GLYPH_COUNT = 8'd2;
  localparam logic [7:0] CFG_KERN_COUNT  = 8'd3;

  localparam logic [15:0] SCALE_RESET      = 16'd256;
  localparam logic [15:0] INV_ASPECT_RESET = 16'd9216;

  localparam logic [6:0]  CODE_NUL     = 7'd0;
  localparam logic [6:0]  CODE_NEWLINE = 7'd10;
  // code - ' ' + 2, modulo 256
  localparam logic [7:0]  GLYPH_BIAS   = 8'd226;
  localparam logic [7:0]  GLYPH_NUL    = 8'd0;
  localparam logic [7:0]  GLYPH_NEWLINE = 8'd1;
  // 0.9 in Q0.16
  localparam logic [16:0] ADV_FRAC     = 17'd58982;

  typedef struct packed {
    cmd_e        cmd;
    logic [6:0]  idx;
    logic [6:0]  code;
    logic [6:0]  code2;
    logic [31:0] px;
    logic [31:0] py;
    logic [15:0] sw;
    logic [15:0] sh;
    logic [15:0] tu;
    logic [15:0] tv;
    logic [17:0] adv;
  } raw_t;

  typedef struct packed {
    raw_t       raw;
    logic [7:0] glyph;
  } item_t;

  typedef struct packed {
    logic [15:0] scale;
    logic [15:0] inv_aspect;
    logic [7:0]  glyph_count;
    logic [6:0]  kern_count;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_KSCAN,
    S_KADD,
    S_GLYPH,
    S_MW,
    S_MH,
    S_MADV,
    S_MADV2,
    S_PEN,
    S_VMUL,
    S_VOUT,
    S_BAD
  } back_state_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/gqtl_ram.sv
`default_nettype none
module gqtl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: hdl/gqtl_front.sv
`default_nettype none
module gqtl_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire gqtl_pkg::raw_t in_raw_i,
  output logic                q_valid_o,
  output gqtl_pkg::item_t     q_item_o,
  input  wire logic           q_pop_i
);

  gqtl_pkg::item_t slot_q [2];
  gqtl_pkg::item_t push_item;
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;
  logic            push, pop;

  // map character code to glyph index
  always_comb begin
    push_item.raw = in_raw_i;
    priority if (in_raw_i.code == gqtl_pkg::CODE_NUL) begin
      push_item.glyph = gqtl_pkg::GLYPH_NUL;
    end else if (in_raw_i.code == gqtl_pkg::CODE_NEWLINE) begin
      push_item.glyph = gqtl_pkg::GLYPH_NEWLINE;
    end else begin
      push_item.glyph = {1'b0, in_raw_i.code} + gqtl_pkg::GLYPH_BIAS;
    end
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rp_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= push_item;
    end
  end

endmodule
`default_nettype wire

// File: hdl/gqtl_back.sv
`default_nettype none
`include "glyph_quad_text_layout_assert.svh"
module gqtl_back #(
  parameter int GLYPH_DEPTH = 128,
  parameter int KERN_DEPTH  = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire gqtl_pkg::cfg_t  cfg_i,
  input  wire logic            q_valid_i,
  input  wire gqtl_pkg::item_t q_item_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic signed [31:0]   vert_x_o,
  output logic signed [31:0]   vert_y_o,
  output logic [16:0]          vert_u_o,
  output logic [16:0]          vert_v_o,
  output logic                 bad_char_o,
  output logic                 last_o
);

  localparam int GA  = (GLYPH_DEPTH > 1) ? $clog2(GLYPH_DEPTH) : 1;
  localparam int KA  = (KERN_DEPTH > 1) ? $clog2(KERN_DEPTH) : 1;
  localparam int KCW = $clog2(KERN_DEPTH + 1);

  gqtl_pkg::back_state_e state_q, state_d;
  gqtl_pkg::item_t       cur_q;
  logic signed [31:0]    pen_q, base_q;
  logic [6:0]            prev_q;
  logic [KCW-1:0]        kidx_q, limit;
  logic                  kv_q, kv_d, kissue, kmatch, kdone;
  logic signed [62:0]    prod_q;
  logic signed [45:0]    mul_a;
  logic signed [16:0]    mul_b;
  logic signed [41:0]    xp_q;
  logic [23:0]           w_q, h_q;
  logic [1:0]            vk_q;
  logic                  bad, glyph_we, kern_we, out_load;
  logic signed [42:0]    vx_pre;
  logic signed [32:0]    vy_pre;

  logic                  out_valid_q, bad_q, last_q;
  logic signed [31:0]    vx_q, vy_q;
  logic [16:0]           vu_q, vv_q;

  logic [49:0] shape_rd;
  logic [63:0] tex_rd;
  logic [45:0] kern_rd;

  gqtl_ram #(.WIDTH(50), .DEPTH(GLYPH_DEPTH)) u_shape_ram (
    .clk_i   (clk_i),
    .we_i    (glyph_we),
    .waddr_i (GA'(q_item_i.raw.idx)),
    .wdata_i ({q_item_i.raw.px, q_item_i.raw.adv}),
    .raddr_i (GA'(cur_q.glyph)),
    .rdata_o (shape_rd)
  );

  gqtl_ram #(.WIDTH(64), .DEPTH(GLYPH_DEPTH)) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (glyph_we),
    .waddr_i (GA'(q_item_i.raw.idx)),
    .wdata_i ({q_item_i.raw.sw, q_item_i.raw.sh, q_item_i.raw.tu, q_item_i.raw.tv}),
    .raddr_i (GA'(cur_q.glyph)),
    .rdata_o (tex_rd)
  );

  gqtl_ram #(.WIDTH(46), .DEPTH(KERN_DEPTH)) u_kern_ram (
    .clk_i   (clk_i),
    .we_i    (kern_we),
    .waddr_i (KA'(q_item_i.raw.idx)),
    .wdata_i ({q_item_i.raw.code, q_item_i.raw.code2, q_item_i.raw.px}),
    .raddr_i (KA'(kidx_q)),
    .rdata_o (kern_rd)
  );

  assign limit  = (32'(cfg_i.kern_count) < KERN_DEPTH) ? KCW'(cfg_i.kern_count)
                                                      : KCW'(KERN_DEPTH);
  assign kmatch = kv_q && (kern_rd[45:39] == prev_q) && (kern_rd[38:32] == cur_q.raw.code);
  assign kdone  = !kv_q && (kidx_q == limit);
  assign bad    = !(cur_q.glyph < cfg_i.glyph_count) || !(32'(cur_q.glyph) < GLYPH_DEPTH);

  // corner order: top-left, top-right, bottom-right, bottom-left
  assign vx_pre = $signed({xp_q[41], xp_q})
                + ((vk_q == 2'd1 || vk_q == 2'd2) ? $signed({19'b0, w_q}) : 43'sd0);
  assign vy_pre = $signed({base_q[31], base_q})
                + ((vk_q == 2'd0 || vk_q == 2'd1) ? $signed({9'b0, h_q}) : 33'sd0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gqtl_pkg::S_IDLE: begin
        if (q_valid_i && q_item_i.raw.cmd == gqtl_pkg::CMD_CHAR) state_d = gqtl_pkg::S_KSCAN;
      end
      gqtl_pkg::S_KSCAN: begin
        priority if (kmatch) state_d = gqtl_pkg::S_KADD;
        else if (kdone) state_d = gqtl_pkg::S_GLYPH;
      end
      gqtl_pkg::S_KADD:  state_d = gqtl_pkg::S_GLYPH;
      gqtl_pkg::S_GLYPH: state_d = bad ? gqtl_pkg::S_BAD : gqtl_pkg::S_MW;
      gqtl_pkg::S_MW:    state_d = gqtl_pkg::S_MH;
      gqtl_pkg::S_MH:    state_d = gqtl_pkg::S_MADV;
      gqtl_pkg::S_MADV:  state_d = gqtl_pkg::S_MADV2;
      gqtl_pkg::S_MADV2: state_d = gqtl_pkg::S_PEN;
      gqtl_pkg::S_PEN:   state_d = gqtl_pkg::S_VMUL;
      gqtl_pkg::S_VMUL:  state_d = gqtl_pkg::S_VOUT;
      gqtl_pkg::S_VOUT: begin
        if (out_load) state_d = (vk_q == 2'd3) ? gqtl_pkg::S_IDLE : gqtl_pkg::S_VMUL;
      end
      gqtl_pkg::S_BAD: begin
        if (out_load) state_d = gqtl_pkg::S_IDLE;
      end
      default: state_d = gqtl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    glyph_we = 1'b0;
    kern_we  = 1'b0;
    kissue   = 1'b0;
    out_load = 1'b0;
    mul_a    = '0;
    mul_b    = $signed({1'b0, cfg_i.scale});
    unique case (state_q)
      gqtl_pkg::S_IDLE: begin
        q_pop_o  = q_valid_i;
        glyph_we = q_valid_i && q_item_i.raw.cmd == gqtl_pkg::CMD_LOAD_GLYPH
                   && (32'(q_item_i.raw.idx) < GLYPH_DEPTH);
        kern_we  = q_valid_i && q_item_i.raw.cmd == gqtl_pkg::CMD_LOAD_KERN
                   && (32'(q_item_i.raw.idx) < KERN_DEPTH);
      end
      gqtl_pkg::S_KSCAN: begin
        kissue = !kmatch && (kidx_q < limit);
        mul_a  = 46'($signed(kern_rd[31:0]));
      end
      gqtl_pkg::S_GLYPH: mul_a = 46'($signed(shape_rd[49:18]));
      gqtl_pkg::S_MW:    mul_a = $signed({30'b0, tex_rd[63:48]});
      gqtl_pkg::S_MH:    mul_a = $signed({30'b0, tex_rd[47:32]});
      gqtl_pkg::S_MADV:  mul_a = 46'($signed(shape_rd[17:0]));
      gqtl_pkg::S_MADV2: begin
        mul_a = 46'($signed(prod_q[34:0]));
        mul_b = $signed(gqtl_pkg::ADV_FRAC);
      end
      gqtl_pkg::S_VMUL: begin
        mul_a = 46'(vx_pre);
        mul_b = $signed({1'b0, cfg_i.inv_aspect});
      end
      gqtl_pkg::S_VOUT: begin
        // hold the corner product steady while the output slot is busy
        mul_a    = 46'(vx_pre);
        mul_b    = $signed({1'b0, cfg_i.inv_aspect});
        out_load = !out_valid_q || out_ready_i;
      end
      gqtl_pkg::S_BAD:  out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign kv_d = kissue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gqtl_pkg::S_IDLE;
      pen_q       <= '0;
      base_q      <= '0;
      prev_q      <= '0;
      kidx_q      <= '0;
      kv_q        <= 1'b0;
      vk_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      kv_q    <= kv_d;
      if (kissue) kidx_q <= kidx_q + 1'b1;
      if (state_q == gqtl_pkg::S_IDLE && q_valid_i) begin
        kidx_q <= '0;
        if (q_item_i.raw.cmd == gqtl_pkg::CMD_START) begin
          pen_q  <= q_item_i.raw.px;
          base_q <= q_item_i.raw.py;
          prev_q <= '0;
        end
      end
      if (state_q == gqtl_pkg::S_KADD) pen_q <= gqtl_pkg::sat32(64'(pen_q) + 64'(prod_q >>> 9));
      if (state_q == gqtl_pkg::S_GLYPH) prev_q <= cur_q.raw.code;
      if (state_q == gqtl_pkg::S_PEN) begin
        pen_q <= gqtl_pkg::sat32(64'(pen_q) + 64'(prod_q >>> 24));
        vk_q  <= '0;
      end
      if (state_q == gqtl_pkg::S_VOUT && out_load) vk_q <= vk_q + 2'd1;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (state_q == gqtl_pkg::S_IDLE && q_pop_o) cur_q <= q_item_i;
    if (state_q == gqtl_pkg::S_MW) xp_q <= 42'($signed(pen_q)) + 42'(prod_q >>> 8);
    if (state_q == gqtl_pkg::S_MH) w_q <= prod_q[31:8];
    if (state_q == gqtl_pkg::S_MADV) h_q <= prod_q[31:8];
    if (out_load) begin
      if (state_q == gqtl_pkg::S_BAD) begin
        vx_q  <= '0;
        vy_q  <= '0;
        vu_q  <= '0;
        vv_q  <= '0;
        bad_q <= 1'b1;
        last_q <= 1'b1;
      end else begin
        vx_q  <= gqtl_pkg::sat32(64'(prod_q >>> 14));
        vy_q  <= gqtl_pkg::sat32(64'(vy_pre));
        vu_q  <= {1'b0, tex_rd[31:16]}
               + ((vk_q == 2'd1 || vk_q == 2'd2) ? {1'b0, tex_rd[63:48]} : 17'd0);
        vv_q  <= {1'b0, tex_rd[15:0]}
               + ((vk_q == 2'd2 || vk_q == 2'd3) ? {1'b0, tex_rd[47:32]} : 17'd0);
        bad_q <= 1'b0;
        last_q <= (vk_q == 2'd3);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign vert_x_o    = vx_q;
  assign vert_y_o    = vy_q;
  assign vert_u_o    = vu_q;
  assign vert_v_o    = vv_q;
  assign bad_char_o  = bad_q;
  assign last_o      = last_q;

  `GQTL_ASSERT_NEXT(a_kv_only_scan, state_q != gqtl_pkg::S_KSCAN, !kv_q)
  `GQTL_ASSERT_NEXT(a_last_corner_idle, state_q == gqtl_pkg::S_VOUT && out_load && vk_q == 2'd3, state_q == gqtl_pkg::S_IDLE)
  `GQTL_ASSERT_NOW(a_load_slot_free, !out_load || !out_valid_q || out_ready_i)

endmodule
`default_nettype wire

// File: hdl/glyph_quad_text_layout.sv
// Channel  Handshake                 Payload
// cfg      cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
// in       in_valid_i/in_ready_o     cmd_i .. advance_i
// out      out_valid_o/out_ready_i   vert_x_o .. last_o
// Load and start items are taken by the back end in its idle state. A character leaves
// the queue, then a kerning search over at most min(kern_count, KERN_DEPTH) entries
// and pen update follow (one store read per cycle, an early match ends it), then the
// bad-glyph output or the shared-multiplier work and vertex output.
// A two-entry queue lets input transfers continue while the back end works.
// Output stalls hold the back end in its vertex and bad-glyph output states. No clearing pass.
`default_nettype none
module glyph_quad_text_layout #(
  parameter int GLYPH_DEPTH = 128,
  parameter int KERN_DEPTH  = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [7:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         cmd_i,
  input  wire logic [6:0]         entry_index_i,
  input  wire logic [6:0]         char_code_i,
  input  wire logic [6:0]         second_code_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic [15:0]        size_w_i,
  input  wire logic [15:0]        size_h_i,
  input  wire logic [15:0]        tex_u_i,
  input  wire logic [15:0]        tex_v_i,
  input  wire logic signed [17:0] advance_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      vert_x_o,
  output logic signed [31:0]      vert_y_o,
  output logic [16:0]             vert_u_o,
  output logic [16:0]             vert_v_o,
  output logic                    bad_char_o,
  output logic                    last_o
);

  gqtl_pkg::cfg_t  cfg_q;
  gqtl_pkg::raw_t  in_raw;
  gqtl_pkg::item_t q_item;
  logic            q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale       <= gqtl_pkg::SCALE_RESET;
      cfg_q.inv_aspect  <= gqtl_pkg::INV_ASPECT_RESET;
      cfg_q.glyph_count <= '0;
      cfg_q.kern_count  <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == gqtl_pkg::CFG_SCALE) cfg_q.scale <= cfg_data_i;
      if (cfg_index_i == gqtl_pkg::CFG_INV_ASPECT) cfg_q.inv_aspect <= cfg_data_i;
      if (cfg_index_i == gqtl_pkg::CFG_GLYPH_COUNT) cfg_q.glyph_count <= cfg_data_i[7:0];
      if (cfg_index_i == gqtl_pkg::CFG_KERN_COUNT) cfg_q.kern_count <= cfg_data_i[6:0];
    end
  end

  always_comb begin
    in_raw.cmd   = gqtl_pkg::cmd_e'(cmd_i);
    in_raw.idx   = entry_index_i;
    in_raw.code  = char_code_i;
    in_raw.code2 = second_code_i;
    in_raw.px    = pos_x_i;
    in_raw.py    = pos_y_i;
    in_raw.sw    = size_w_i;
    in_raw.sh    = size_h_i;
    in_raw.tu    = tex_u_i;
    in_raw.tv    = tex_v_i;
    in_raw.adv   = advance_i;
  end

  gqtl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_raw_i   (in_raw),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  gqtl_back #(.GLYPH_DEPTH(GLYPH_DEPTH), .KERN_DEPTH(KERN_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .vert_x_o    (vert_x_o),
    .vert_y_o    (vert_y_o),
    .vert_u_o    (vert_u_o),
    .vert_v_o    (vert_v_o),
    .bad_char_o  (bad_char_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire

// File: tb/tb_glyph_quad_text_layout.sv
`timescale 1ns / 1ps

module tb_glyph_quad_text_layout;

  localparam int GLYPHS     = 128;
  localparam int KERNS      = 64;
  localparam int CYCLE_CAP  = 800000;
  localparam int DRAIN_WAIT = 200;
  localparam int LONG_HOLD  = 400;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [16:0] u;
    logic [16:0] v;
    logic        bad;
    logic        last;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = '0;
  logic [6:0]  entry_index = '0;
  logic [6:0]  char_code = '0;
  logic [6:0]  second_code = '0;
  logic [31:0] pos_x = '0;
  logic [31:0] pos_y = '0;
  logic [15:0] size_w = '0;
  logic [15:0] size_h = '0;
  logic [15:0] tex_u = '0;
  logic [15:0] tex_v = '0;
  logic [17:0] advance = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] vert_x;
  logic [31:0] vert_y;
  logic [16:0] vert_u;
  logic [16:0] vert_v;
  logic        bad_char;
  logic        last;

  glyph_quad_text_layout u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .entry_index_i (entry_index),
    .char_code_i   (char_code),
    .second_code_i (second_code),
    .pos_x_i       (pos_x),
    .pos_y_i       (pos_y),
    .size_w_i      (size_w),
    .size_h_i      (size_h),
    .tex_u_i       (tex_u),
    .tex_v_i       (tex_v),
    .advance_i     (advance),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .vert_x_o      (vert_x),
    .vert_y_o      (vert_y),
    .vert_u_o      (vert_u),
    .vert_v_o      (vert_v),
    .bad_char_o    (bad_char),
    .last_o        (last)
  );

  always #5 clk_i = ~clk_i;

  // layout state mirrored from accepted items
  longint      shape_gx  [GLYPHS];
  longint      shape_adv [GLYPHS];
  int          tex_w [GLYPHS], tex_h [GLYPHS], tex_u0 [GLYPHS], tex_v0 [GLYPHS];
  logic [6:0]  kern_first [KERNS], kern_second [KERNS];
  longint      kern_amount [KERNS];
  longint      pen_x, base_y;
  logic [6:0]  prev_code;
  int          scale_q, inv_aspect_q, glyph_count_q, kern_count_q;

  gqtl_pkg::raw_t pending_q [$];
  vertex_t        vertex_q [$];
  gqtl_pkg::raw_t cur_item;
  logic           in_sent = 1'b0;

  // stimulus bookkeeping
  bit          glyph_loaded [256];
  logic [6:0]  loaded_codes [$];

  int snd_idle_pct = 29;
  int rcv_idle_pct = 59;
  int hold_reqs = 0, hold_done = 0, hold_left = 0;
  int errors = 0, cycles = 0;
  int n_items = 0, n_chars = 0, n_vertices = 0, n_bad = 0;

  function automatic int glyph_of(logic [6:0] code);
    if (code == gqtl_pkg::CODE_NUL) return int'(gqtl_pkg::GLYPH_NUL);
    if (code == gqtl_pkg::CODE_NEWLINE) return int'(gqtl_pkg::GLYPH_NEWLINE);
    return int'(8'(code + gqtl_pkg::GLYPH_BIAS));
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic vertex_t corner(longint x, longint y, int u, int v, logic is_last);
    vertex_t c;
    c.x    = 32'(clip32((x * inv_aspect_q) >>> 14));
    c.y    = 32'(clip32(y));
    c.u    = 17'(u);
    c.v    = 17'(v);
    c.bad  = 1'b0;
    c.last = is_last;
    return c;
  endfunction

  task automatic layout_item(gqtl_pkg::raw_t it);
    int      g, lim, w, h;
    longint  xp, adv_step;
    vertex_t bad_v;
    n_items++;
    case (it.cmd)
      gqtl_pkg::CMD_LOAD_GLYPH: begin
        shape_gx[it.idx]  = longint'(signed'(it.px));
        shape_adv[it.idx] = longint'(signed'(it.adv));
        tex_w[it.idx]  = it.sw;
        tex_h[it.idx]  = it.sh;
        tex_u0[it.idx] = it.tu;
        tex_v0[it.idx] = it.tv;
      end
      gqtl_pkg::CMD_LOAD_KERN: begin
        if (it.idx < KERNS) begin
          kern_first[it.idx]  = it.code;
          kern_second[it.idx] = it.code2;
          kern_amount[it.idx] = longint'(signed'(it.px));
        end
      end
      gqtl_pkg::CMD_START: begin
        pen_x     = longint'(signed'(it.px));
        base_y    = longint'(signed'(it.py));
        prev_code = '0;
      end
      default: begin
        n_chars++;
        lim = (kern_count_q < KERNS) ? kern_count_q : KERNS;
        for (int i = 0; i < lim; i++) begin
          if (kern_first[i] == prev_code && kern_second[i] == it.code) begin
            pen_x = clip32(pen_x + ((kern_amount[i] * scale_q) >>> 9));
            break;
          end
        end
        prev_code = it.code;
        g = glyph_of(it.code);
        if (g >= glyph_count_q || g >= GLYPHS) begin
          bad_v = '{x: '0, y: '0, u: '0, v: '0, bad: 1'b1, last: 1'b1};
          vertex_q.push_back(bad_v);
        end else begin
          xp = pen_x + ((shape_gx[g] * scale_q) >>> 8);
          w  = int'((longint'(tex_w[g]) * scale_q) >> 8);
          h  = int'((longint'(tex_h[g]) * scale_q) >> 8);
          vertex_q.push_back(corner(xp, base_y + h, tex_u0[g], tex_v0[g], 1'b0));
          vertex_q.push_back(corner(xp + w, base_y + h, tex_u0[g] + tex_w[g], tex_v0[g],
                                    1'b0));
          vertex_q.push_back(corner(xp + w, base_y, tex_u0[g] + tex_w[g],
                                    tex_v0[g] + tex_h[g], 1'b0));
          vertex_q.push_back(corner(xp, base_y, tex_u0[g], tex_v0[g] + tex_h[g], 1'b1));
          adv_step = (shape_adv[g] * scale_q * longint'(gqtl_pkg::ADV_FRAC)) >>> 24;
          pen_x = clip32(pen_x + adv_step);
        end
      end
    endcase
  endtask

  // input channel: accept at the rising edge, present the next at the falling edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) begin
      layout_item(cur_item);
      in_sent = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_sent)) begin
      in_sent = 1'b0;
      if (pending_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
        cur_item    = pending_q.pop_front();
        cmd         <= cur_item.cmd;
        entry_index <= cur_item.idx;
        char_code   <= cur_item.code;
        second_code <= cur_item.code2;
        pos_x       <= cur_item.px;
        pos_y       <= cur_item.py;
        size_w      <= cur_item.sw;
        size_h      <= cur_item.sh;
        tex_u       <= cur_item.tu;
        tex_v       <= cur_item.tv;
        advance     <= cur_item.adv;
        in_valid    <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side: random stalls, plus a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_reqs != hold_done) begin
      hold_done++;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    vertex_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (vertex_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected vertex x=%h y=%h u=%h v=%h bad=%b last=%b", $time,
                 vert_x, vert_y, vert_u, vert_v, bad_char, last);
      end else begin
        want = vertex_q.pop_front();
        n_vertices++;
        if (want.bad) n_bad++;
        if (vert_x !== want.x) begin
          errors++;
          $display("%0t: vert_x expected %h actual %h", $time, want.x, vert_x);
        end
        if (vert_y !== want.y) begin
          errors++;
          $display("%0t: vert_y expected %h actual %h", $time, want.y, vert_y);
        end
        if (vert_u !== want.u) begin
          errors++;
          $display("%0t: vert_u expected %h actual %h", $time, want.u, vert_u);
        end
        if (vert_v !== want.v) begin
          errors++;
          $display("%0t: vert_v expected %h actual %h", $time, want.v, vert_v);
        end
        if (bad_char !== want.bad) begin
          errors++;
          $display("%0t: bad_char expected %b actual %b", $time, want.bad, bad_char);
        end
        if (last !== want.last) begin
          errors++;
          $display("%0t: last expected %b actual %b", $time, want.last, last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [7:0] index, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (index)
      gqtl_pkg::CFG_SCALE:       scale_q       = data;
      gqtl_pkg::CFG_INV_ASPECT:  inv_aspect_q  = data;
      gqtl_pkg::CFG_GLYPH_COUNT: glyph_count_q = data[7:0];
      gqtl_pkg::CFG_KERN_COUNT:  kern_count_q  = data[6:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_layout(int sc, int ia, int gc, int kc);
    write_reg(gqtl_pkg::CFG_SCALE, 16'(sc));
    write_reg(gqtl_pkg::CFG_INV_ASPECT, 16'(ia));
    write_reg(gqtl_pkg::CFG_GLYPH_COUNT, 16'(gc));
    write_reg(gqtl_pkg::CFG_KERN_COUNT, 16'(kc));
  endtask

  // hold until the engine has drained, then give loads and starts time to retire
  task automatic drain();
    while (pending_q.size() != 0 || in_valid || vertex_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic gqtl_pkg::raw_t rand_item(gqtl_pkg::cmd_e c);
    gqtl_pkg::raw_t it;
    it.cmd   = c;
    it.idx   = 7'($urandom);
    it.code  = 7'($urandom);
    it.code2 = 7'($urandom);
    it.px    = $urandom;
    it.py    = $urandom;
    it.sw    = 16'($urandom);
    it.sh    = 16'($urandom);
    it.tu    = 16'($urandom);
    it.tv    = 16'($urandom);
    it.adv   = 18'($urandom);
    return it;
  endfunction

  function automatic logic [31:0] modest(int bits);
    return 32'(int'($urandom_range((1 << bits) - 1)) - (1 << (bits - 1)));
  endfunction

  function automatic logic [6:0] known_code();
    return loaded_codes[$urandom_range(loaded_codes.size() - 1)];
  endfunction

  // never read a glyph that was not loaded
  function automatic logic [6:0] safe_code(logic [6:0] code);
    int g;
    g = glyph_of(code);
    if (g < glyph_count_q && g < GLYPHS && !glyph_loaded[g]) return known_code();
    return code;
  endfunction

  function automatic void push_glyph(gqtl_pkg::raw_t it);
    int code;
    it.cmd = gqtl_pkg::CMD_LOAD_GLYPH;
    glyph_loaded[it.idx] = 1'b1;
    code = (it.idx == gqtl_pkg::GLYPH_NUL) ? gqtl_pkg::CODE_NUL :
           (it.idx == gqtl_pkg::GLYPH_NEWLINE) ? gqtl_pkg::CODE_NEWLINE :
           int'(it.idx) + 30;
    if (code <= 127) loaded_codes.push_back(7'(code));
    pending_q.push_back(it);
  endfunction

  function automatic void push_char(logic [6:0] code);
    gqtl_pkg::raw_t it;
    it = rand_item(gqtl_pkg::CMD_CHAR);
    it.code = safe_code(code);
    pending_q.push_back(it);
  endfunction

  function automatic void push_kern(int idx, logic [31:0] amount);
    gqtl_pkg::raw_t it;
    it = rand_item(gqtl_pkg::CMD_LOAD_KERN);
    it.idx   = 7'(idx);
    it.code  = ($urandom_range(3) == 0) ? gqtl_pkg::CODE_NUL : known_code();
    it.code2 = known_code();
    it.px    = amount;
    pending_q.push_back(it);
  endfunction

  task automatic random_text(int n);
    gqtl_pkg::raw_t it;
    int             len, cnt;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(9) < 7) begin
        it = rand_item(gqtl_pkg::CMD_START);
        if ($urandom_range(4) != 0) begin
          it.px = modest(26);
          it.py = modest(26);
        end
        pending_q.push_back(it);
        len = $urandom_range(3, 8);
        for (int i = 0; i < len; i++) push_char(($urandom_range(6) == 0) ?
                                                7'($urandom) : known_code());
        cnt += len + 1;
      end else begin
        case ($urandom_range(2))
          0: begin
            it = rand_item(gqtl_pkg::CMD_LOAD_GLYPH);
            if ($urandom_range(1)) it.px = modest(22);
            push_glyph(it);
          end
          1: push_kern($urandom_range(127), modest(24));
          default: push_char(7'($urandom));
        endcase
        cnt++;
      end
    end
  endtask

  initial begin
    gqtl_pkg::raw_t it;
    logic [6:0]     dir_codes [9];
    dir_codes = '{gqtl_pkg::CODE_NUL, gqtl_pkg::CODE_NEWLINE, 7'd32, 7'd65, 7'd66,
                  7'd101, 7'd111, 7'd126, 7'd127};
    pen_x = 0;
    base_y = 0;
    prev_code = '0;
    scale_q = gqtl_pkg::SCALE_RESET;
    inv_aspect_q = gqtl_pkg::INV_ASPECT_RESET;
    glyph_count_q = 0;
    kern_count_q = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: glyphs with extreme metrics, kerning pairs, ignored load, reset config
    foreach (dir_codes[i]) begin
      it = rand_item(gqtl_pkg::CMD_LOAD_GLYPH);
      it.idx = 7'(glyph_of(dir_codes[i]));
      case (i % 3)
        0: begin it.px = 32'h7fffffff; it.adv = 18'h1ffff; it.sw = '1; it.sh = '1;
                 it.tu = '1; it.tv = '1; end
        1: begin it.px = 32'h80000000; it.adv = 18'h20000; it.sw = '0; it.sh = '0;
                 it.tu = '0; it.tv = '0; end
        default: begin it.px = modest(18); it.adv = 18'h0e000; end
      endcase
      push_glyph(it);
    end
    push_kern(0, 32'h7fffffff);
    push_kern(1, 32'h80000000);
    push_kern(2, modest(20));
    push_kern(3, modest(20));
    push_kern(127, $urandom);
    push_char(7'd65);
    it = rand_item(gqtl_pkg::CMD_START);
    it.px = 32'h7fffffff;
    it.py = 32'h80000000;
    pending_q.push_back(it);
    drain();

    set_layout(256, 16384, 128, 4);
    foreach (dir_codes[i]) push_char(dir_codes[i]);
    push_char(7'd5);
    push_char(7'd31);
    // fill the rest of the kerning table while this phase runs
    for (int i = 4; i < KERNS; i++) push_kern(i, ($urandom_range(3) == 0) ? $urandom :
                                                 modest(22));
    drain();

    set_layout(65535, 65535, 128, 127);
    hold_reqs++;
    random_text(12);
    drain();

    snd_idle_pct = 59;
    rcv_idle_pct = 29;
    set_layout(1, 1, 98, 0);
    random_text(12);
    drain();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_layout($urandom_range(1, 65535), $urandom_range(1, 65535), $urandom_range(128),
               $urandom_range(64));
    random_text(12);
    drain();

    $display("Run covered %0d items (%0d characters) over five layout settings,", n_items,
             n_chars);
    $display("checking %0d vertices of which %0d were bad-glyph results.", n_vertices,
             n_bad);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
